// ----- design/mhf_pkg.sv -----
// Package for the multicast hash filter: field widths, CRC constants and the
// elaboration-time functions that build the CRC column table.
// No dependencies.
package mhf_pkg;

    localparam int ADDR_W   = 48;
    localparam int INDEX_W  = 6;
    localparam int TABLE_W  = 64;
    localparam int HALF_W   = 32;
    localparam int CRC_W    = 32;
    localparam int ADDR_BYTES = 6;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [TABLE_W-1:0] table_t;
    typedef logic [ADDR_W-1:0][INDEX_W-1:0] col_tab_t;

    // Bit-serial reflected CRC over the six address bytes, first byte from the
    // top of the word and each byte least significant bit first. It is only
    // evaluated on constants while the design elaborates.
    function automatic logic [CRC_W-1:0] crc_raw(addr_t addr, logic [CRC_W-1:0] init);
        logic [CRC_W-1:0] crc;
        logic [7:0]       data_byte;
        logic             fb;
        crc = init;
        for (int b = 0; b < ADDR_BYTES; b++) begin
            data_byte = addr[8*(ADDR_BYTES-1-b) +: 8];
            for (int k = 0; k < 8; k++) begin
                fb = crc[0] ^ data_byte[0];
                crc = (crc >> 1) ^ (fb ? CRC_POLY : '0);
                data_byte = data_byte >> 1;
            end
        end
        return crc;
    endfunction

    // The CRC is linear in the data once the preset is split off, so the hash
    // is the preset term XORed with one column for every set address bit.
    function automatic col_tab_t hash_columns();
        col_tab_t         cols;
        logic [CRC_W-1:0] crc;
        for (int j = 0; j < ADDR_W; j++) begin
            crc = crc_raw(addr_t'(1) << j, '0);
            cols[j] = crc[CRC_W-1 -: INDEX_W];
        end
        return cols;
    endfunction

    function automatic index_t hash_base();
        logic [CRC_W-1:0] crc;
        crc = crc_raw('0, CRC_PRESET);
        return crc[CRC_W-1 -: INDEX_W];
    endfunction

endpackage

// ----- design/multicast_hash_filter_unit.sv -----
// Multicast hash filter: an accepted address waits in the input register, and its
// result word is held in the result register until it is taken; one address is
// accepted every cycle when the output is taken.
// The address sits in an input register; the CRC hash (a fixed XOR network) and
// the table update run between it and the result register.
// Synchronous active-low reset clears the hash table and both valid flags.
module multicast_hash_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [47:0] s_mac_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_hash_index,
    output logic        m_accepted,
    output logic [31:0] m_table_low,
    output logic [31:0] m_table_high
);

    localparam mhf_pkg::col_tab_t HASH_COLS = mhf_pkg::hash_columns();
    localparam mhf_pkg::index_t   HASH_BASE = mhf_pkg::hash_base();

    logic              in_valid_reg;
    mhf_pkg::addr_t    addr_reg;
    logic              out_valid_reg;
    mhf_pkg::index_t   index_reg;
    logic              accepted_reg;
    mhf_pkg::table_t   table_reg;
    mhf_pkg::table_t   table_next;
    mhf_pkg::table_t   out_table_reg;
    mhf_pkg::index_t   hash;
    logic              multicast;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign multicast = addr_reg[40];

    always_comb begin
        hash = HASH_BASE;
        for (int j = 0; j < mhf_pkg::ADDR_W; j++) begin
            if (addr_reg[j]) begin
                hash = hash ^ HASH_COLS[j];
            end
        end
    end

    always_comb begin
        table_next = table_reg;
        if (multicast) begin
            table_next[hash] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            table_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                table_reg     <= table_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            addr_reg <= s_mac_address;
        end
        if (advance) begin
            index_reg     <= multicast ? hash : '0;
            accepted_reg  <= multicast;
            out_table_reg <= table_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_index = index_reg;
    assign m_accepted   = accepted_reg;
    assign m_table_low  = out_table_reg[mhf_pkg::HALF_W-1:0];
    assign m_table_high = out_table_reg[mhf_pkg::TABLE_W-1:mhf_pkg::HALF_W];

    // Table bits are only ever set between resets.
    a_table_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (($past(table_reg) & ~table_reg) == '0))
        else $error("hash table bit cleared without reset");

    // A word that reports a match must point at a bit that is set in the table.
    a_index_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> table_reg[m_hash_index])
        else $error("reported hash bit is not set in table");

    // A non-multicast word carries a zero index.
    a_skip_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_hash_index == '0))
        else $error("skipped address reports nonzero index");

endmodule

// ----- dv/tb_multicast_hash_filter_unit.sv -----
// Self-checking testbench for the multicast hash filter: directed addresses, then
// random multicast and unicast traffic with random stalls on both channels.
// Depends on mhf_pkg and multicast_hash_filter_unit.
module tb_multicast_hash_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [mhf_pkg::INDEX_W-1:0] hash_index;
        logic                        accepted;
        logic [mhf_pkg::HALF_W-1:0]  table_low;
        logic [mhf_pkg::HALF_W-1:0]  table_high;
    } filter_word_t;

    typedef struct packed {
        logic [mhf_pkg::ADDR_W-1:0] mac;
        logic                       typed_in;
        filter_word_t               word;
    } stim_row_t;

    localparam filter_word_t EMPTY_MISS = '{hash_index: '0, accepted: 1'b0,
                                            table_low: '0, table_high: '0};

    // Rows marked typed_in carry their own expected word; the rest go to the predictor.
    localparam int DIR_ROWS = 18;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{48'h0000_0000_0000, 1'b1, EMPTY_MISS},
        '{48'hFEFF_FFFF_FFFF, 1'b1, EMPTY_MISS},
        '{48'h0000_0000_0001, 1'b1, EMPTY_MISS},
        '{48'h0200_0000_0000, 1'b1, EMPTY_MISS},
        '{48'h0100_0000_0000, 1'b0, EMPTY_MISS},
        '{48'hFFFF_FFFF_FFFF, 1'b0, EMPTY_MISS},
        '{48'hFFFF_FFFF_FFFF, 1'b0, EMPTY_MISS},
        '{48'h0100_5E00_0001, 1'b0, EMPTY_MISS},
        '{48'h0100_5E7F_FFFF, 1'b0, EMPTY_MISS},
        '{48'h3333_0000_0001, 1'b0, EMPTY_MISS},
        '{48'h3333_FFFF_FFFF, 1'b0, EMPTY_MISS},
        '{48'h0180_C200_0000, 1'b0, EMPTY_MISS},
        '{48'h0180_C200_000E, 1'b0, EMPTY_MISS},
        '{48'h0000_5E00_0101, 1'b0, EMPTY_MISS},
        '{48'hFEFF_FFFF_FFFF, 1'b0, EMPTY_MISS},
        '{48'h0100_0000_0001, 1'b0, EMPTY_MISS},
        '{48'h0180_0000_0000, 1'b0, EMPTY_MISS},
        '{48'h8100_0000_0000, 1'b0, EMPTY_MISS}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [mhf_pkg::ADDR_W-1:0] s_mac_address;
    logic                       m_valid;
    logic                       m_ready;
    logic [5:0]                 m_hash_index;
    logic                       m_accepted;
    logic [31:0]                m_table_low;
    logic [31:0]                m_table_high;

    logic [mhf_pkg::TABLE_W-1:0] filter_table;
    filter_word_t                expected_words [$];
    int                          errors = 0;
    int                          cycles = 0;
    logic                        send_burst = 1'b0;
    logic                        take_burst = 1'b0;

    multicast_hash_filter_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mac_address (s_mac_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_index  (m_hash_index),
        .m_accepted    (m_accepted),
        .m_table_low   (m_table_low),
        .m_table_high  (m_table_high)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Bit-serial reflected CRC; address bits enter byte by byte from the top,
    // each byte starting at its least significant bit.
    function automatic logic [mhf_pkg::INDEX_W-1:0] mac_hash(logic [mhf_pkg::ADDR_W-1:0] mac);
        logic [mhf_pkg::CRC_W-1:0] crc;
        logic                      din;
        crc = mhf_pkg::CRC_PRESET;
        for (int n = 0; n < mhf_pkg::ADDR_W; n++) begin
            din = mac[8 * (mhf_pkg::ADDR_BYTES - 1 - n / 8) + n % 8];
            if (crc[0] ^ din)
                crc = (crc >> 1) ^ mhf_pkg::CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc[mhf_pkg::CRC_W-1 -: mhf_pkg::INDEX_W];
    endfunction

    function automatic filter_word_t predict_filter(logic [mhf_pkg::ADDR_W-1:0] mac);
        filter_word_t w;
        w.hash_index = '0;
        w.accepted   = 1'b0;
        if (mac[40]) begin
            w.hash_index = mac_hash(mac);
            w.accepted   = 1'b1;
            filter_table[w.hash_index] = 1'b1;
        end
        w.table_low  = filter_table[mhf_pkg::HALF_W-1:0];
        w.table_high = filter_table[mhf_pkg::TABLE_W-1:mhf_pkg::HALF_W];
        return w;
    endfunction

    function automatic int draw_gap(logic burst);
        return burst ? 0 : int'($urandom_range(0, 8));
    endfunction

    // Called just after a rising edge; returns just after the edge that took the word.
    task automatic send_address(logic [mhf_pkg::ADDR_W-1:0] mac, logic typed_in,
                                filter_word_t typed);
        filter_word_t predicted;
        int           gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = ~send_burst;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mac_address <= mac;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_filter(mac);
        expected_words.push_back(typed_in ? typed : predicted);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Result side: random stalls, every accepted word checked against the oldest expectation.
    initial begin
        filter_word_t exp_w;
        int           gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                take_burst = ~take_burst;
            gap = draw_gap(take_burst);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, index %0h", $time,
                         m_hash_index);
            end else begin
                exp_w = expected_words.pop_front();
                check_field("hash_index", 64'(exp_w.hash_index), 64'(m_hash_index));
                check_field("accepted", 64'(exp_w.accepted), 64'(m_accepted));
                check_field("table_low", 64'(exp_w.table_low), 64'(m_table_low));
                check_field("table_high", 64'(exp_w.table_high), 64'(m_table_high));
            end
        end
    end

    initial begin
        logic [mhf_pkg::ADDR_W-1:0] mac;
        logic [mhf_pkg::ADDR_W-1:0] repeat_pool [4];
        int                         pick;
        filter_table  = '0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_mac_address <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_address(DIRECTED[r].mac, DIRECTED[r].typed_in, DIRECTED[r].word);

        foreach (repeat_pool[p])
            repeat_pool[p] = {16'($urandom_range(0, 65535)), 32'($urandom())} | 48'h0100_0000_0000;

        // Mostly well-formed multicast words; the rest are repeats, unicast words and raw addresses.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            mac  = {16'($urandom_range(0, 65535)), 32'($urandom())};
            pick = $urandom_range(0, 99);
            if (pick < 70)
                mac[40] = 1'b1;
            else if (pick < 80)
                mac = repeat_pool[$urandom_range(0, 3)];
            else if (pick < 90)
                mac[40] = 1'b0;
            send_address(mac, 1'b0, EMPTY_MISS);
        end
        s_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/mhf_pkg.sv
design/multicast_hash_filter_unit.sv
dv/tb_multicast_hash_filter_unit.sv
